### rtl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// shared types and codes for the sorted set store
// ----------------------------------------------------------------------------
package sss_pkg;

   localparam int VALUE_W  = 31;
   localparam int ITEM_W   = 32;
   localparam int COUNT_W  = 4;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_REJECT = 2'd1,
      ST_ABSENT = 2'd2
   } status_code_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic ins;
      logic del;
   } shift_cmd_type;

endpackage

### rtl/sss_req_if.sv
// ----------------------------------------------------------------------------
// sss_req_if
// request channel: operation code and signed key
// ----------------------------------------------------------------------------
interface sss_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        req_type;
   logic signed [sss_pkg::ITEM_W-1:0] item_value;

   modport source (output valid, output req_type, output item_value, input ready);
   modport sink (input valid, input req_type, input item_value, output ready);
endinterface

### rtl/sss_rsp_if.sv
// ----------------------------------------------------------------------------
// sss_rsp_if
// response channel: status, membership flag and element count
// ----------------------------------------------------------------------------
interface sss_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic                         found;
   logic [sss_pkg::COUNT_W-1:0]  count;

   modport source (output valid, output status, output found, output count, input ready);
   modport sink (input valid, input status, input found, input count, output ready);
endinterface

### rtl/sss_cell.sv
// ----------------------------------------------------------------------------
// sss_cell
// one slot of the sorted chain: holds a value, compares it with the key and
// shifts toward either neighbor on insert or delete
// ----------------------------------------------------------------------------
module sss_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sss_pkg::VALUE_W-1:0]   key,
   input  logic                          cmp_en,
   input  logic                          active,
   input  sss_pkg::shift_cmd_type        cmd,
   input  logic                          left_lt,
   input  logic [sss_pkg::VALUE_W-1:0]   left_value,
   input  logic [sss_pkg::VALUE_W-1:0]   right_value,
   output logic [sss_pkg::VALUE_W-1:0]   value,
   output logic                          lt,
   output logic                          eq
);

   logic [sss_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                        lt_ff, lt_in;
   logic                        eq_ff, eq_in;

   always_comb begin
      value_in = value_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (cmp_en) begin
         lt_in = active && (value_ff < key);
         eq_in = active && (value_ff == key);
      end
      if (cmd.ins && !lt_ff) begin
         value_in = left_lt ? key : left_value;
      end else if (cmd.del && !lt_ff) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

   assign value = value_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

### rtl/sorted_set_store_unit.sv
// ----------------------------------------------------------------------------
// sorted_set_store_unit
// an accepted request registers its key and the cell compare results, then
//   EXEC commits the shift and loads the response once the output is free;
//   the next request is taken only in IDLE, even while a response still waits
// reset: empties the set and drops any pending response; slot contents are
//   left as they are and only slots below the count are ever looked at
// ----------------------------------------------------------------------------
module sorted_set_store_unit #(
   parameter int SET_SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   sss_req_if.sink    req_ch,
   sss_rsp_if.source  rsp_ch
);

   localparam int CAP = SET_SLOTS - 1;
   localparam int CW  = $clog2(SET_SLOTS);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAP);

   sss_pkg::ctl_state_type      state_ff, state_in;
   sss_pkg::req_code_type       op_ff;
   logic [sss_pkg::VALUE_W-1:0] key_ff;
   logic                        neg_ff;
   logic [CW-1:0]               count_ff, count_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  status_ff;
   logic                        found_ff;
   logic [sss_pkg::COUNT_W-1:0] rsp_count_ff;

   logic                        accept;
   logic                        out_free;
   logic                        cmp_en;
   logic                        commit;
   logic [sss_pkg::VALUE_W-1:0] key_w;
   sss_pkg::shift_cmd_type      cmd;

   logic [sss_pkg::VALUE_W-1:0] cell_value [CAP];
   logic [CAP-1:0]              cell_lt;
   logic [CAP-1:0]              cell_eq;

   logic                        present;
   logic                        found_w;
   logic                        do_ins;
   logic                        do_del;
   sss_pkg::status_code_type    status_w;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sss_pkg::S_IDLE: begin
            if (accept) state_in = sss_pkg::S_EXEC;
         end
         sss_pkg::S_EXEC: begin
            if (out_free) state_in = sss_pkg::S_IDLE;
         end
         default: state_in = sss_pkg::S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ch.ready = 1'b0;
      commit       = 1'b0;
      unique case (state_ff)
         sss_pkg::S_IDLE: req_ch.ready = 1'b1;
         sss_pkg::S_EXEC: commit = out_free;
         default: begin
            req_ch.ready = 1'b0;
            commit       = 1'b0;
         end
      endcase
   end

   assign cmp_en = accept;
   assign key_w  = accept ? req_ch.item_value[sss_pkg::VALUE_W-1:0] : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sss_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= sss_pkg::req_code_type'(req_ch.req_type);
         key_ff <= req_ch.item_value[sss_pkg::VALUE_W-1:0];
         neg_ff <= req_ch.item_value[sss_pkg::ITEM_W-1];
      end
   end

   // cell chain
   genvar gi;
   generate
      for (gi = 0; gi < CAP; gi++) begin : g_cell
         logic                        left_lt_w;
         logic [sss_pkg::VALUE_W-1:0] left_value_w;
         logic [sss_pkg::VALUE_W-1:0] right_value_w;

         if (gi == 0) begin : g_head
            assign left_lt_w    = 1'b1;
            assign left_value_w = key_w;
         end else begin : g_body
            assign left_lt_w    = cell_lt[gi-1];
            assign left_value_w = cell_value[gi-1];
         end

         if (gi == CAP - 1) begin : g_tail
            assign right_value_w = cell_value[gi];
         end else begin : g_mid
            assign right_value_w = cell_value[gi+1];
         end

         sss_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .key         (key_w),
            .cmp_en      (cmp_en),
            .active      (CW'(gi) < count_ff),
            .cmd         (cmd),
            .left_lt     (left_lt_w),
            .left_value  (left_value_w),
            .right_value (right_value_w),
            .value       (cell_value[gi]),
            .lt          (cell_lt[gi]),
            .eq          (cell_eq[gi])
         );
      end
   endgenerate

   // request decode
   always_comb begin
      present  = !neg_ff && (|cell_eq);
      found_w  = present;
      do_ins   = 1'b0;
      do_del   = 1'b0;
      status_w = sss_pkg::ST_DONE;
      unique case (op_ff)
         sss_pkg::REQ_ADD: begin
            if ((count_ff == CAP_CNT) || present || neg_ff) begin
               status_w = sss_pkg::ST_REJECT;
            end else begin
               do_ins = 1'b1;
            end
         end
         sss_pkg::REQ_REMOVE: begin
            priority if (neg_ff || (count_ff == '0)) begin
               status_w = sss_pkg::ST_REJECT;
            end else if (!present) begin
               status_w = sss_pkg::ST_ABSENT;
            end else begin
               do_del = 1'b1;
            end
         end
         sss_pkg::REQ_QUERY: status_w = sss_pkg::ST_DONE;
         default: begin
            status_w = sss_pkg::ST_REJECT;
            found_w  = 1'b0;
         end
      endcase
   end

   assign cmd.ins = commit && do_ins;
   assign cmd.del = commit && do_del;

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.del) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff    <= status_w;
         found_ff     <= found_w;
         rsp_count_ff <= sss_pkg::COUNT_W'(count_in);
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.found  = found_ff;
   assign rsp_ch.count  = rsp_count_ff;

endmodule

### rtl/sss_checker.sv
// ----------------------------------------------------------------------------
// sss_checker
// port level checks on the response stream of the sorted set store
// ----------------------------------------------------------------------------
module sss_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_status,
   input logic                         rsp_found,
   input logic [sss_pkg::COUNT_W-1:0]  rsp_count
);

   logic [sss_pkg::COUNT_W-1:0] last_count_ff, last_count_in;
   logic                        rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      last_count_in = last_count_ff;
      if (rsp_take) last_count_in = rsp_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
      end else begin
         last_count_ff <= last_count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found) && $stable(rsp_count))
      else $error("response changed while stalled");

   a_absent_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sss_pkg::ST_ABSENT) |-> !rsp_found)
      else $error("absent response flags a member");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_count == last_count_ff)
         || (rsp_count == last_count_ff + sss_pkg::COUNT_W'(1))
         || (rsp_count + sss_pkg::COUNT_W'(1) == last_count_ff))
      else $error("count moved by more than one");

   a_count_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_take && (rsp_status != sss_pkg::ST_DONE) |-> rsp_count == last_count_ff)
      else $error("failed transaction changed the count");

endmodule

bind sorted_set_store_unit sss_checker u_sss_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_found  (rsp_ch.found),
   .rsp_count  (rsp_ch.count)
);

### sim/tb_sorted_set_store_unit.sv
// ----------------------------------------------------------------------------
// tb_sorted_set_store_unit
// self-checking bench for the sorted set store: directed corner requests,
// then random add/remove/query traffic that swings the set between empty and
// full, with random gaps on both channels; every response is compared against
// a tracked copy of the set
// ----------------------------------------------------------------------------
module tb_sorted_set_store_unit;

   localparam int          VALUE_W      = sss_pkg::VALUE_W;
   localparam int          ITEM_W       = sss_pkg::ITEM_W;
   localparam int          COUNT_W      = sss_pkg::COUNT_W;
   localparam int          SLOT_COUNT   = 16;
   localparam int          SET_CAPACITY = SLOT_COUNT - 1;
   localparam int          RANDOM_ITEMS = 1300;
   localparam int          STALL_LIMIT  = 1000;
   localparam logic [1:0]  REQ_UNUSED   = 2'd3;

   typedef struct packed {
      sss_pkg::status_code_type status;
      logic                     found;
      logic [COUNT_W-1:0]       count;
   } set_answer_type;

   class sorted_set_tracker;
      logic [VALUE_W-1:0] slot_keys [SET_CAPACITY];
      int unsigned        stored;
      set_answer_type     expected_answers [$];
      int unsigned        errors;
      int unsigned        requests;
      int unsigned        responses;
      int unsigned        full_rejects;
      int unsigned        empty_rejects;

      function new();
         stored        = 0;
         errors        = 0;
         requests      = 0;
         responses     = 0;
         full_rejects  = 0;
         empty_rejects = 0;
      endfunction

      task report(input string msg);
         if (errors < 40) begin
            $display("mismatch: %s", msg);
         end
         errors++;
      endtask

      function int pending();
         return expected_answers.size();
      endfunction

      function logic [VALUE_W-1:0] pick_member();
         if (stored == 0) begin
            return VALUE_W'($urandom_range(0, 40));
         end
         return slot_keys[$urandom_range(0, stored - 1)];
      endfunction

      task note_request(input logic [1:0] code, input logic [ITEM_W-1:0] value);
         logic               negative;
         logic [VALUE_W-1:0] key;
         int unsigned        pos;
         int unsigned        idx;
         logic               present;
         set_answer_type     ans;
         negative = value[ITEM_W-1];
         key      = value[VALUE_W-1:0];
         pos      = 0;
         while (pos < stored && slot_keys[pos] < key) begin
            pos++;
         end
         present    = !negative && pos < stored && slot_keys[pos] == key;
         ans.status = sss_pkg::ST_DONE;
         ans.found  = present;
         case (code)
            sss_pkg::REQ_ADD: begin
               if (stored >= SET_CAPACITY || present || negative) begin
                  ans.status = sss_pkg::ST_REJECT;
                  if (stored >= SET_CAPACITY && !present && !negative) begin
                     full_rejects++;
                  end
               end else begin
                  for (idx = stored; idx > pos; idx--) begin
                     slot_keys[idx] = slot_keys[idx - 1];
                  end
                  slot_keys[pos] = key;
                  stored++;
               end
            end
            sss_pkg::REQ_REMOVE: begin
               if (negative || stored == 0) begin
                  ans.status = sss_pkg::ST_REJECT;
                  if (!negative) begin
                     empty_rejects++;
                  end
               end else if (!present) begin
                  ans.status = sss_pkg::ST_ABSENT;
               end else begin
                  for (idx = pos; idx + 1 < stored; idx++) begin
                     slot_keys[idx] = slot_keys[idx + 1];
                  end
                  stored--;
               end
            end
            sss_pkg::REQ_QUERY: begin
               ans.status = sss_pkg::ST_DONE;
            end
            default: begin
               ans.status = sss_pkg::ST_REJECT;
               ans.found  = 1'b0;
            end
         endcase
         ans.count = COUNT_W'(stored);
         expected_answers.push_back(ans);
         requests++;
      endtask

      task check_response(input logic [1:0] status, input logic found,
                          input logic [COUNT_W-1:0] count);
         set_answer_type want;
         responses++;
         if (expected_answers.size() == 0) begin
            report($sformatf("response with nothing outstanding: status %0d found %0d count %0d",
                             status, found, count));
            return;
         end
         want = expected_answers.pop_front();
         if (status !== want.status) begin
            report($sformatf("response %0d: status %0d, expected %0d",
                             responses, status, want.status));
         end
         if (found !== want.found) begin
            report($sformatf("response %0d: found %0d, expected %0d",
                             responses, found, want.found));
         end
         if (count !== want.count) begin
            report($sformatf("response %0d: count %0d, expected %0d",
                             responses, count, want.count));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   bit                quiet;
   int unsigned       idle_cycles;
   sorted_set_tracker tracker;

   sss_req_if req_ch ();
   sss_rsp_if rsp_ch ();

   sorted_set_store_unit #(
      .SET_SLOTS (SLOT_COUNT)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // accepted transactions on each channel
   always @(posedge clock) begin
      if (!reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
         tracker.note_request(req_ch.req_type, req_ch.item_value);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         tracker.check_response(rsp_ch.status, rsp_ch.found, rsp_ch.count);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side back-pressure
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   task push_request(input logic [1:0] code, input logic [ITEM_W-1:0] value);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= code;
      req_ch.item_value <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int unsigned        i;
      int unsigned        roll;
      logic [1:0]         code;
      logic [ITEM_W-1:0]  value;
      bit                 growing;
      tracker = new();
      quiet   = 1'b0;
      growing = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= sss_pkg::REQ_ADD;
      req_ch.item_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty store, negative keys, unused code, key extremes
      push_request(sss_pkg::REQ_QUERY, 32'd5);
      push_request(sss_pkg::REQ_REMOVE, 32'd5);
      push_request(sss_pkg::REQ_ADD, 32'hFFFF_FFFF);
      push_request(sss_pkg::REQ_REMOVE, 32'h8000_0000);
      push_request(sss_pkg::REQ_QUERY, 32'hFFFF_FFF9);
      push_request(REQ_UNUSED, 32'd9);
      push_request(sss_pkg::REQ_ADD, 32'd0);
      push_request(sss_pkg::REQ_ADD, 32'h7FFF_FFFF);
      push_request(sss_pkg::REQ_ADD, 32'd0);
      push_request(sss_pkg::REQ_QUERY, 32'd0);
      push_request(sss_pkg::REQ_QUERY, 32'h7FFF_FFFF);
      push_request(sss_pkg::REQ_REMOVE, 32'd17);
      // fill to capacity in scrambled order
      for (i = 1; i <= SET_CAPACITY - 2; i++) begin
         push_request(sss_pkg::REQ_ADD, ITEM_W'(((i * 5) % 13 + 1) * 1000));
      end
      push_request(sss_pkg::REQ_ADD, 32'd4500);
      push_request(sss_pkg::REQ_ADD, 32'd3000);
      push_request(REQ_UNUSED, 32'd3000);
      push_request(sss_pkg::REQ_REMOVE, 32'd0);
      push_request(sss_pkg::REQ_REMOVE, 32'h7FFF_FFFF);
      hold_until_drained();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            quiet = ($urandom_range(0, 3) == 0);
         end
         if (i % 60 == 0) begin
            growing = ~growing;
         end
         if (i == RANDOM_ITEMS / 2) begin
            hold_until_drained();
         end
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            code = REQ_UNUSED;
         end else if (roll < 17) begin
            code = sss_pkg::REQ_QUERY;
         end else if (roll < (growing ? 75 : 35)) begin
            code = sss_pkg::REQ_ADD;
         end else begin
            code = sss_pkg::REQ_REMOVE;
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            value = {1'b1, VALUE_W'($urandom)};
         end else if (roll < 15) begin
            value = {1'b0, VALUE_W'($urandom)};
         end else if (roll < 50 && code != sss_pkg::REQ_ADD) begin
            value = {1'b0, tracker.pick_member()};
         end else begin
            value = ITEM_W'($urandom_range(0, 40));
         end
         push_request(code, value);
      end

      hold_until_drained();
      repeat (8) @(posedge clock);

      $display("run covered %0d requests and %0d responses, %0d errors",
               tracker.requests, tracker.responses, tracker.errors);
      $display("adds refused on a full set: %0d, removes refused on an empty set: %0d",
               tracker.full_rejects, tracker.empty_rejects);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
